// File: src/hhfs_pkg.sv
`default_nettype none

package hhfs_pkg;

    // Sizes
    localparam int MAX_HAPS  = 1024;
    localparam int IDX_W     = 10;
    localparam int BANK_AW   = 11;
    localparam int PROB_W    = 32;
    localparam int SUM_W     = 42;
    localparam int NH_W      = 11;
    localparam int FRAC_BITS = 31;
    localparam int LOSS_W    = NH_W + PROB_W;
    localparam int T_W       = 76;
    localparam int P_W       = 108;
    localparam int Y_W       = P_W - FRAC_BITS;
    localparam int Q_W       = 33;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Fixed-point constants (Q1.31)
    localparam logic [PROB_W-1:0] ONE  = 32'h8000_0000;
    localparam logic [PROB_W-1:0] PMAX = 32'h8000_0000;

    localparam logic [NH_W-1:0] NUM_HAPS_RST = 11'd2;

    // Register index decode (bit 2 of the byte address)
    localparam logic REG_NUM_HAPS = 1'b0;

    typedef struct packed {
        logic [IDX_W-1:0]  hap_index;
        logic [PROB_W-1:0] match_prob;
        logic [PROB_W-1:0] rec_prob;
        logic              first_site;
        logic              last_hap;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  out_index;
        logic [PROB_W-1:0] forward_value;
        logic [SUM_W-1:0]  site_norm;
        logic              norm_valid;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [Y_W-1:0]   num;
        logic [SUM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROB_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIVGO,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// File: src/hhfs_if.sv
`default_nettype none

interface hhfs_in_if;
    logic               valid;
    logic               ready;
    hhfs_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hhfs_out_if;
    logic                valid;
    logic                ready;
    hhfs_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/haplotype_hmm_forward_step.sv
`default_nettype none

// Forward step of a haplotype-copying HMM.
// in_ch: one request per haplotype of a site, haplotypes of a site in a row,
// last_hap set on the final one. out_ch: one result per request, in order;
// site_norm/norm_valid carry the site sum on the last haplotype.
// APB port: num_haps at byte address 0, to be written only while the block is
// idle; the block itself does not enforce this. Items are processed one at a
// time. A first-site item, or any item while the previous site sum is zero,
// goes from accept straight to the finish state. Other items pass through a
// bank read, eight steps of the shared 32x32 multiplier and a 33-step
// bit-serial divide by the previous site sum. A saturating quotient ends the
// divide early.
// The next request is taken as soon as the result sits in the output
// register; if that register is still full when a result is ready, the block
// holds the result and stops taking requests until out_ch.ready returns.
// Reset clears the site sums and bank select and sets num_haps to 2. The
// likelihood banks are not cleared; no haplotype is read before it is written.
module haplotype_hmm_forward_step (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    hhfs_in_if.sink                           in_ch,
    hhfs_out_if.source                        out_ch,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hhfs_pkg::APB_AW-1:0] paddr,
    input  wire logic [hhfs_pkg::APB_DW-1:0] pwdata,
    output logic      [hhfs_pkg::APB_DW-1:0] prdata,
    output logic                              pready
);
    import hhfs_pkg::*;

    state_t state_reg, state_next;

    logic [NH_W-1:0]   num_haps;
    logic              accept;
    logic              out_free;
    logic              commit;

    // Item registers
    logic [IDX_W-1:0]  idx_reg;
    logic [PROB_W-1:0] match_reg;
    logic [PROB_W-1:0] rec_reg;
    logic              last_reg;

    // Site state
    logic              bank_reg;
    logic [SUM_W-1:0]  prev_sum_reg;
    logic [SUM_W-1:0]  run_sum_reg;

    // Datapath
    logic [SUM_W-1:0]  diff_reg;
    logic [PROB_W-1:0] old_reg;
    logic [PROB_W-1:0] rec0_reg;
    logic [2:0]        step_reg;
    logic [2*PROB_W-1:0] prod_reg;
    logic [T_W-1:0]    t_reg;
    logic [P_W-1:0]    p_reg;
    logic [PROB_W-1:0] value_reg;

    logic [PROB_W-1:0] rd_data;
    logic [PROB_W-1:0] match_clamp;
    logic [PROB_W-1:0] rec_clamp;
    logic [NH_W-1:0]   nm1;
    logic [LOSS_W-1:0] loss;
    logic [PROB_W-1:0] op_a;
    logic [PROB_W-1:0] op_b;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_next;

    out_item_t out_data_reg;
    logic      out_valid_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    hhfs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .num_haps (num_haps)
    );

    hhfs_bank_ram u_ram (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr ({~bank_reg, idx_reg}),
        .wr_data (value_reg),
        .rd_en   (accept),
        .rd_addr ({bank_reg, in_ch.data.hap_index}),
        .rd_data (rd_data)
    );

    assign div_req.start = (state_reg == ST_DIVGO);
    assign div_req.num   = p_reg[P_W-1:FRAC_BITS];
    assign div_req.den   = prev_sum_reg;

    hhfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Handshake and input clamps
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign commit      = (state_reg == ST_FIN) && out_free;
    assign match_clamp = (in_ch.data.match_prob > PMAX) ? PMAX : in_ch.data.match_prob;
    assign rec_clamp   = (in_ch.data.rec_prob > PMAX) ? PMAX : in_ch.data.rec_prob;

    // rec0 = ONE - (N-1)*rec, floored at zero
    assign nm1  = (num_haps == '0) ? '0 : (num_haps - NH_W'(1));
    assign loss = LOSS_W'(nm1) * LOSS_W'(rec_reg);

    // Running sum with saturation
    assign sum_wide = {1'b0, run_sum_reg} + (SUM_W+1)'(value_reg);
    assign sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and ready
    always_comb
    begin
        state_next  = state_reg;
        in_ch.ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    if (in_ch.data.first_site || (prev_sum_reg == '0))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (step_reg == 3'd7)
                begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Multiplier operand select per step
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            3'd0:
            begin
                op_a = diff_reg[PROB_W-1:0];
                op_b = rec_reg;
            end
            3'd1:
            begin
                op_a = PROB_W'(diff_reg[SUM_W-1:PROB_W]);
                op_b = rec_reg;
            end
            3'd2:
            begin
                op_a = old_reg;
                op_b = rec0_reg;
            end
            3'd4:
            begin
                op_a = t_reg[PROB_W-1:0];
                op_b = match_reg;
            end
            3'd5:
            begin
                op_a = t_reg[2*PROB_W-1:PROB_W];
                op_b = match_reg;
            end
            3'd6:
            begin
                op_a = PROB_W'(t_reg[T_W-1:2*PROB_W]);
                op_b = match_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Item capture, operand prep, multiply-accumulate
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg   <= in_ch.data.hap_index;
            match_reg <= match_clamp;
            rec_reg   <= rec_clamp;
            last_reg  <= in_ch.data.last_hap;
            value_reg <= in_ch.data.first_site ? match_clamp : '0;
        end
        if (state_reg == ST_LOAD)
        begin
            old_reg  <= rd_data;
            diff_reg <= (prev_sum_reg > SUM_W'(rd_data)) ? (prev_sum_reg - SUM_W'(rd_data)) : '0;
            rec0_reg <= (loss >= LOSS_W'(ONE)) ? '0 : PROB_W'(LOSS_W'(ONE) - loss);
            step_reg <= '0;
            t_reg    <= '0;
            p_reg    <= P_W'(prev_sum_reg) << (FRAC_BITS - 1);
        end
        if (state_reg == ST_MUL)
        begin
            step_reg <= step_reg + 3'd1;
            prod_reg <= op_a * op_b;
            case (step_reg)
                3'd1:    t_reg <= t_reg + T_W'(prod_reg);
                3'd2:    t_reg <= t_reg + (T_W'(prod_reg) << PROB_W);
                3'd3:    t_reg <= t_reg + T_W'(prod_reg);
                3'd5:    p_reg <= p_reg + P_W'(prod_reg);
                3'd6:    p_reg <= p_reg + (P_W'(prod_reg) << PROB_W);
                3'd7:    p_reg <= p_reg + (P_W'(prod_reg) << (2*PROB_W));
                default: t_reg <= t_reg;
            endcase
        end
        if ((state_reg == ST_DIV) && div_rsp.done)
        begin
            value_reg <= div_rsp.quot;
        end
    end

    // Site sums and bank select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg     <= 1'b0;
            prev_sum_reg <= '0;
            run_sum_reg  <= '0;
        end
        else if (commit)
        begin
            if (last_reg)
            begin
                bank_reg     <= ~bank_reg;
                prev_sum_reg <= sum_next;
                run_sum_reg  <= '0;
            end
            else
            begin
                run_sum_reg <= sum_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg.out_index     <= idx_reg;
            out_data_reg.forward_value <= value_reg;
            out_data_reg.site_norm     <= last_reg ? sum_next : '0;
            out_data_reg.norm_valid    <= last_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

`default_nettype wire

// File: src/hhfs_bank_ram.sv
`default_nettype none

module hhfs_bank_ram (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [hhfs_pkg::BANK_AW-1:0] wr_addr,
    input  wire logic [hhfs_pkg::PROB_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [hhfs_pkg::BANK_AW-1:0] rd_addr,
    output logic      [hhfs_pkg::PROB_W-1:0]  rd_data
);
    import hhfs_pkg::*;

    logic [PROB_W-1:0] mem [2*MAX_HAPS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/hhfs_cfg.sv
`default_nettype none

module hhfs_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hhfs_pkg::APB_AW-1:0] paddr,
    input  wire logic [hhfs_pkg::APB_DW-1:0] pwdata,
    output logic      [hhfs_pkg::APB_DW-1:0] prdata,
    output logic                              pready,
    output logic      [hhfs_pkg::NH_W-1:0]   num_haps
);
    import hhfs_pkg::*;

    logic [NH_W-1:0] num_haps_reg;
    logic            wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_NUM_HAPS);

    // num_haps register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_haps_reg <= NUM_HAPS_RST;
        end
        else if (wr_hit)
        begin
            num_haps_reg <= pwdata[NH_W-1:0];
        end
    end

    // Readback
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_NUM_HAPS)
        begin
            prdata = {{(APB_DW-NH_W){1'b0}}, num_haps_reg};
        end
    end

    assign num_haps = num_haps_reg;

endmodule

`default_nettype wire

// File: src/hhfs_div.sv
`default_nettype none

module hhfs_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hhfs_pkg::div_req_t  req,
    output hhfs_pkg::div_rsp_t       rsp
);
    import hhfs_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic             sat_reg;
    logic [5:0]       cnt_reg;
    logic [SUM_W:0]   rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   q_reg;
    logic [PROB_W-1:0] quot_reg;

    logic [SUM_W+1:0] num_hi;
    logic [SUM_W:0]   rem_shift;
    logic             qbit;
    logic [SUM_W:0]   rem_next;
    logic [Q_W-1:0]   q_next;

    assign num_hi = req.num[Y_W-1:Q_W];

    // One quotient bit per cycle, restoring
    always_comb
    begin
        rem_shift = {rem_reg[SUM_W-1:0], low_reg[Q_W-1]};
        qbit      = rem_shift >= {1'b0, req.den};
        rem_next  = qbit ? (rem_shift - {1'b0, req.den}) : rem_shift;
        q_next    = {q_reg[Q_W-2:0], qbit};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (sat_reg || (cnt_reg == 6'd1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= num_hi[SUM_W:0];
            low_reg <= req.num[Q_W-1:0];
            q_reg   <= '0;
            sat_reg <= num_hi >= {2'b00, req.den};
        end
        else if (busy_reg)
        begin
            if (sat_reg)
            begin
                quot_reg <= PMAX;
            end
            else
            begin
                rem_reg <= rem_next;
                low_reg <= {low_reg[Q_W-2:0], 1'b0};
                q_reg   <= q_next;
                quot_reg <= (q_next > {1'b0, PMAX}) ? PMAX : q_next[PROB_W-1:0];
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire
